@@ rtl/cafu_pkg.sv @@
package cafu_pkg;

    localparam int unsigned ModeW    = 6;
    localparam int unsigned WordW    = 16;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned BitIdxW  = 3;
    localparam int unsigned InDataW  = 48;
    localparam int unsigned OutDataW = 24;

    // Operation codes carried in the mode field.
    typedef enum logic [ModeW-1:0] {
        OP_ADD    = 6'd0,
        OP_ADC    = 6'd1,
        OP_SUB    = 6'd2,
        OP_SBC    = 6'd3,
        OP_AND    = 6'd4,
        OP_XOR    = 6'd5,
        OP_OR     = 6'd6,
        OP_CP     = 6'd7,
        OP_INC    = 6'd8,
        OP_DEC    = 6'd9,
        OP_DAA    = 6'd10,
        OP_CPL    = 6'd11,
        OP_SCF    = 6'd12,
        OP_CCF    = 6'd13,
        OP_RLCA   = 6'd14,
        OP_RRCA   = 6'd15,
        OP_RLA    = 6'd16,
        OP_RRA    = 6'd17,
        OP_RLC    = 6'd18,
        OP_RRC    = 6'd19,
        OP_RL     = 6'd20,
        OP_RR     = 6'd21,
        OP_SLA    = 6'd22,
        OP_SRA    = 6'd23,
        OP_SWAP   = 6'd24,
        OP_SRL    = 6'd25,
        OP_BIT    = 6'd26,
        OP_RES    = 6'd27,
        OP_SET    = 6'd28,
        OP_ADDHL  = 6'd29,
        OP_ADDSP  = 6'd30,
        OP_INC16  = 6'd31,
        OP_DEC16  = 6'd32
    } t_alu_op;

    typedef struct packed {
        logic                subtract;
        logic                zero;
        logic                half;
        logic                carry;
    } t_flags;

    typedef struct packed {
        logic [ModeW-1:0]    mode;
        logic [WordW-1:0]    first_operand;
        logic [WordW-1:0]    second_operand;
        logic [BitIdxW-1:0]  bit_index;
        t_flags              flags;
    } t_alu_req;

    typedef struct packed {
        logic [WordW-1:0]    result;
        logic                write_result;
        t_flags              flags;
    } t_alu_rsp;

endpackage

@@ rtl/cafu_core.sv @@
module cafu_core (
    input  cafu_pkg::t_alu_req i_req,
    output cafu_pkg::t_alu_rsp o_rsp
);
    import cafu_pkg::*;

    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] r8;
    logic [ByteW-1:0] daa_adj;
    logic             cin;
    logic             t;
    logic [ByteW:0]   sum9;
    logic [ByteW:0]   diff9;
    logic [4:0]       nib_sum;
    logic [4:0]       nib_diff;
    logic [WordW:0]   sum17;
    logic [12:0]      sum13;
    logic [WordW-1:0] sp_sum;
    t_alu_op          op;

    assign a   = i_req.first_operand[ByteW-1:0];
    assign b   = i_req.second_operand[ByteW-1:0];
    assign cin = i_req.flags.carry;
    assign op  = t_alu_op'(i_req.mode);

    // The carry-in term t is nonzero only for the with-carry forms.
    assign t        = ((op == OP_ADC) || (op == OP_SBC)) ? cin : 1'b0;
    assign sum9     = {1'b0, a} + {1'b0, b} + {{ByteW{1'b0}}, t};
    assign diff9    = {1'b0, a} - {1'b0, b} - {{ByteW{1'b0}}, t};
    assign nib_sum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
    assign nib_diff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
    assign sum17    = {1'b0, i_req.first_operand} + {1'b0, i_req.second_operand};
    assign sum13    = {1'b0, i_req.first_operand[11:0]} + {1'b0, i_req.second_operand[11:0]};
    assign sp_sum   = i_req.first_operand + {{ByteW{b[ByteW-1]}}, b};

    always_comb begin
        o_rsp        = '0;
        o_rsp.flags  = i_req.flags;
        o_rsp.write_result = 1'b1;
        r8           = '0;
        daa_adj      = '0;
        case (op)
            OP_ADD, OP_ADC: begin
                r8 = sum9[ByteW-1:0];
                o_rsp.flags.zero     = (r8 == '0);
                o_rsp.flags.subtract = 1'b0;
                o_rsp.flags.half     = nib_sum[4];
                o_rsp.flags.carry    = sum9[ByteW];
            end
            OP_SUB, OP_SBC, OP_CP: begin
                r8 = diff9[ByteW-1:0];
                o_rsp.flags.zero     = (r8 == '0);
                o_rsp.flags.subtract = 1'b1;
                o_rsp.flags.half     = nib_diff[4];
                o_rsp.flags.carry    = diff9[ByteW];
                // Compare only sets flags.
                if (op == OP_CP) begin
                    r8 = '0;
                    o_rsp.write_result = 1'b0;
                end
            end
            OP_AND: begin
                r8 = a & b;
                o_rsp.flags = '{subtract: 1'b0, zero: (r8 == '0), half: 1'b1, carry: 1'b0};
            end
            OP_XOR, OP_OR: begin
                r8 = (op == OP_XOR) ? (a ^ b) : (a | b);
                o_rsp.flags = '{subtract: 1'b0, zero: (r8 == '0), half: 1'b0, carry: 1'b0};
            end
            OP_INC: begin
                r8 = a + 8'd1;
                o_rsp.flags.zero     = (r8 == '0);
                o_rsp.flags.subtract = 1'b0;
                o_rsp.flags.half     = (r8[3:0] == 4'h0);
            end
            OP_DEC: begin
                r8 = a - 8'd1;
                o_rsp.flags.zero     = (r8 == '0);
                o_rsp.flags.subtract = 1'b1;
                o_rsp.flags.half     = (r8[3:0] == 4'hF);
            end
            OP_DAA: begin
                if (i_req.flags.subtract) begin
                    if (i_req.flags.half) daa_adj[3:0] = 4'h6;
                    if (cin) daa_adj[7:4] = 4'h6;
                    r8 = a - daa_adj;
                end else begin
                    if (i_req.flags.half || (a[3:0] > 4'h9)) daa_adj[3:0] = 4'h6;
                    if (cin || (a > 8'h99)) begin
                        daa_adj[7:4] = 4'h6;
                        o_rsp.flags.carry = 1'b1;
                    end
                    r8 = a + daa_adj;
                end
                o_rsp.flags.zero = (r8 == '0);
                o_rsp.flags.half = 1'b0;
            end
            OP_CPL: begin
                r8 = ~a;
                o_rsp.flags.subtract = 1'b1;
                o_rsp.flags.half     = 1'b1;
            end
            OP_SCF, OP_CCF: begin
                o_rsp.write_result   = 1'b0;
                o_rsp.flags.subtract = 1'b0;
                o_rsp.flags.half     = 1'b0;
                o_rsp.flags.carry    = (op == OP_SCF) ? 1'b1 : ~cin;
            end
            OP_RLCA, OP_RLC, OP_RLA, OP_RL, OP_SLA: begin
                case (op)
                    OP_RLCA, OP_RLC: r8 = {a[6:0], a[7]};
                    OP_RLA, OP_RL:   r8 = {a[6:0], cin};
                    default:         r8 = {a[6:0], 1'b0};
                endcase
                // The accumulator forms always clear zero.
                o_rsp.flags = '{subtract: 1'b0,
                                zero: ((op == OP_RLCA) || (op == OP_RLA)) ? 1'b0 : (r8 == '0),
                                half: 1'b0, carry: a[7]};
            end
            OP_RRCA, OP_RRC, OP_RRA, OP_RR, OP_SRA, OP_SRL: begin
                case (op)
                    OP_RRCA, OP_RRC: r8 = {a[0], a[7:1]};
                    OP_RRA, OP_RR:   r8 = {cin, a[7:1]};
                    OP_SRA:          r8 = {a[7], a[7:1]};
                    default:         r8 = {1'b0, a[7:1]};
                endcase
                o_rsp.flags = '{subtract: 1'b0,
                                zero: ((op == OP_RRCA) || (op == OP_RRA)) ? 1'b0 : (r8 == '0),
                                half: 1'b0, carry: a[0]};
            end
            OP_SWAP: begin
                r8 = {a[3:0], a[7:4]};
                o_rsp.flags = '{subtract: 1'b0, zero: (r8 == '0), half: 1'b0, carry: 1'b0};
            end
            OP_BIT: begin
                o_rsp.write_result   = 1'b0;
                o_rsp.flags.zero     = ~a[i_req.bit_index];
                o_rsp.flags.subtract = 1'b0;
                o_rsp.flags.half     = 1'b1;
            end
            OP_RES: begin
                r8 = a & ~(8'd1 << i_req.bit_index);
            end
            OP_SET: begin
                r8 = a | (8'd1 << i_req.bit_index);
            end
            default: begin
                // Codes outside the table write nothing and keep all flags.
                o_rsp.write_result = 1'b0;
            end
        endcase

        o_rsp.result = {{(WordW-ByteW){1'b0}}, r8};

        // The 16-bit forms override the byte result.
        case (op)
            OP_ADDHL: begin
                o_rsp.result         = sum17[WordW-1:0];
                o_rsp.write_result   = 1'b1;
                o_rsp.flags.subtract = 1'b0;
                o_rsp.flags.half     = sum13[12];
                o_rsp.flags.carry    = sum17[WordW];
            end
            OP_ADDSP: begin
                o_rsp.result         = sp_sum;
                o_rsp.write_result   = 1'b1;
                o_rsp.flags.zero     = 1'b0;
                o_rsp.flags.subtract = 1'b0;
                o_rsp.flags.half     = {1'b0, i_req.first_operand[3:0]} + {1'b0, b[3:0]} > 5'h0F;
                o_rsp.flags.carry    = {1'b0, i_req.first_operand[7:0]} + {1'b0, b} > 9'h0FF;
            end
            OP_INC16: begin
                o_rsp.result       = i_req.first_operand + 16'd1;
                o_rsp.write_result = 1'b1;
                o_rsp.flags        = i_req.flags;
            end
            OP_DEC16: begin
                o_rsp.result       = i_req.first_operand - 16'd1;
                o_rsp.write_result = 1'b1;
                o_rsp.flags        = i_req.flags;
            end
            default: begin
                o_rsp.result = {{(WordW-ByteW){1'b0}}, r8};
            end
        endcase
    end

endmodule

@@ rtl/cpu_alu_flag_unit_top.sv @@
// Arithmetic and flag unit of an 8-bit handheld console CPU.
//
// Items enter on the slave stream (s_axis_*): each carries an operation code,
// two 16-bit operands, a bit index and the current Z, N, H and C flags. For
// every accepted item exactly one result item leaves on the master stream
// (m_axis_*) with the new register value, a write enable and the new flags.
// Flags that an operation does not touch are copied from the item.
//
// The path is an input register, one short block of adders and selection
// logic, and an output register. An accepted item moves from the input
// register into the output register, where its result is offered, once
// that register is free; one item is accepted every cycle without a stall.
//
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more item; only when both are full does
// s_axis_tready drop. Ready is worked out from the register occupancy and
// m_axis_tready, so nothing is lost or repeated under any stall pattern.
//
// Reset (i_rst_n low at a clock edge) empties both registers; the unit has
// no other state and is ready again in the cycle after reset.
module cpu_alu_flag_unit_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // mode[5:0], first_operand[21:6], second_operand[37:22], bit_index[40:38],
    // zero_in[41], subtract_in[42], half_in[43], carry_in[44], zero pad above
    input  logic [cafu_pkg::InDataW-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // result[15:0], write_result[16], zero_out[17], subtract_out[18],
    // half_out[19], carry_out[20], zero pad above
    output logic [cafu_pkg::OutDataW-1:0]  m_axis_tdata
);
    import cafu_pkg::*;

    logic     r_s1_valid;
    t_alu_req r_s1_req;
    logic     r_out_valid;
    t_alu_rsp r_out_rsp;
    t_alu_req in_req;
    t_alu_rsp core_rsp;
    logic     s1_ready;
    logic     out_ready;

    // Unpack the input item; flags are laid out Z, N, H, C from the low end.
    assign in_req.mode           = s_axis_tdata[5:0];
    assign in_req.first_operand  = s_axis_tdata[21:6];
    assign in_req.second_operand = s_axis_tdata[37:22];
    assign in_req.bit_index      = s_axis_tdata[40:38];
    assign in_req.flags.zero     = s_axis_tdata[41];
    assign in_req.flags.subtract = s_axis_tdata[42];
    assign in_req.flags.half     = s_axis_tdata[43];
    assign in_req.flags.carry    = s_axis_tdata[44];

    // The output register frees up when it is empty or being read; the
    // input register frees up when it is empty or moving forward.
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s1_ready      = !r_s1_valid || out_ready;
    assign s_axis_tready = s1_ready;

    cafu_core u_core (
        .i_req (r_s1_req),
        .o_rsp (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && s_axis_tvalid) begin
            r_s1_req <= in_req;
        end
        if (out_ready && r_s1_valid) begin
            r_out_rsp <= core_rsp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OutDataW-21){1'b0}},
                            r_out_rsp.flags.carry, r_out_rsp.flags.half,
                            r_out_rsp.flags.subtract, r_out_rsp.flags.zero,
                            r_out_rsp.write_result, r_out_rsp.result};

    // An accepted item always lands in the input register.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_s1_valid)
        else $error("accepted item did not reach the input register");

    // A blocked item in the input register is neither dropped nor changed.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_ready) |=> (r_s1_valid && $stable(r_s1_req)))
        else $error("input register lost or changed a blocked item");

    // Compare never writes its target register.
    a_cp_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_ready && (r_s1_req.mode == OP_CP)) |=> !r_out_rsp.write_result)
        else $error("compare produced a register write");

    // 16-bit increment and decrement leave every flag as it came in.
    a_inc16_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_ready &&
         ((r_s1_req.mode == OP_INC16) || (r_s1_req.mode == OP_DEC16)))
        |=> (r_out_rsp.flags == $past(r_s1_req.flags)))
        else $error("16-bit increment or decrement changed a flag");

endmodule
